// ===== rtl/core/sqs_pkg.sv =====
// ----------------------------------------------------------------------------
// sqs_pkg
// Shared types and codes for the stack/queue store.
// ----------------------------------------------------------------------------
package sqs_pkg;

    localparam int DATA_W = 32;

    // command codes
    localparam logic [2:0] CMD_PUSH_TOP    = 3'd0;
    localparam logic [2:0] CMD_PUSH_BOTTOM = 3'd1;
    localparam logic [2:0] CMD_POP         = 3'd2;
    localparam logic [2:0] CMD_PRINT       = 3'd3;
    localparam logic [2:0] CMD_NOP         = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_DATA  = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]               cmd;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [1:0]               status;
        logic                     last;
    } rsp_t;

endpackage

// ===== rtl/core/stack_queue_store.sv =====
// ----------------------------------------------------------------------------
// stack_queue_store
// Bounded double-ended store of signed 32-bit values in a ring buffer.
// ----------------------------------------------------------------------------
// Requests arrive on s_valid/s_ready/s_data (cmd, value); results leave on
// m_valid/m_ready/m_data (data, status, last).
// Push top / push bottom / pop give no result, except a push on a full store
// (status full) or a pop on an empty store (status empty), whose single
// result is registered and shows in the cycle after the request is taken.
// Nop and unused codes do nothing.
// Print walks the ring from the top, one RAM read per cycle while m_ready is
// high or no result is pending; the request first sets the walk state, then
// each read loads the RAM's read register, which feeds the result directly.
// A print holds off new requests for the whole walk; a print of an empty
// store does nothing.
// When the receiver stalls, the walk pauses and the current result holds.
// A new request is taken in the cycle the pending result leaves.
// Reset (aresetn low, synchronous) empties the store; entry contents are not
// cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module stack_queue_store #(
    parameter int DEPTH = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sqs_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output sqs_pkg::rsp_t m_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;

    typedef enum logic {ST_IDLE, ST_PRINT} state_t;

    state_t                      state_reg, state_next;
    logic [IDX_W-1:0]            top_reg, top_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [IDX_W-1:0]            rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]            remain_reg, remain_next;
    logic                        m_valid_reg, m_valid_next;
    logic [1:0]                  m_status_reg, m_status_next;
    logic                        m_last_reg, m_last_next;
    logic                        m_ram_reg, m_ram_next;

    logic                        accept;
    logic                        out_free;
    logic                        full, empty;
    logic [IDX_W-1:0]            top_dec, top_inc, rd_idx_inc, bottom_pos;
    logic [SUM_W-1:0]            bottom_sum;
    logic                        ram_we, ram_re;
    logic [IDX_W-1:0]            ram_waddr;
    logic [sqs_pkg::DATA_W-1:0]  ram_rdata;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    assign top_dec    = (top_reg == '0) ? IDX_W'(DEPTH - 1) : top_reg - 1'b1;
    assign top_inc    = (top_reg == IDX_W'(DEPTH - 1)) ? '0 : top_reg + 1'b1;
    assign rd_idx_inc = (rd_idx_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;

    // count < DEPTH here, so the sum stays below twice the depth
    assign bottom_sum = SUM_W'(top_reg) + SUM_W'(count_reg);
    assign bottom_pos = (bottom_sum >= SUM_W'(DEPTH)) ?
                        IDX_W'(bottom_sum - SUM_W'(DEPTH)) : IDX_W'(bottom_sum);

    assign ram_re = (state_reg == ST_PRINT) && out_free;

    always_comb begin
        state_next    = state_reg;
        top_next      = top_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        remain_next   = remain_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        m_ram_next    = m_ram_reg;
        ram_we        = 1'b0;
        ram_waddr     = top_dec;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.cmd)
                        sqs_pkg::CMD_PUSH_TOP, sqs_pkg::CMD_PUSH_BOTTOM: begin
                            if (full) begin
                                m_valid_next  = 1'b1;
                                m_status_next = sqs_pkg::STAT_FULL;
                                m_last_next   = 1'b1;
                                m_ram_next    = 1'b0;
                            end else begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (s_data.cmd == sqs_pkg::CMD_PUSH_TOP) begin
                                    top_next = top_dec;
                                end else begin
                                    ram_waddr = bottom_pos;
                                end
                            end
                        end
                        sqs_pkg::CMD_POP: begin
                            if (empty) begin
                                m_valid_next  = 1'b1;
                                m_status_next = sqs_pkg::STAT_EMPTY;
                                m_last_next   = 1'b1;
                                m_ram_next    = 1'b0;
                            end else begin
                                top_next   = top_inc;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        sqs_pkg::CMD_PRINT: begin
                            if (!empty) begin
                                state_next  = ST_PRINT;
                                rd_idx_next = top_reg;
                                remain_next = count_reg;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PRINT: begin
                if (ram_re) begin
                    m_valid_next  = 1'b1;
                    m_status_next = sqs_pkg::STAT_DATA;
                    m_last_next   = (remain_reg == CNT_W'(1));
                    m_ram_next    = 1'b1;
                    rd_idx_next   = rd_idx_inc;
                    remain_next   = remain_reg - 1'b1;
                    if (remain_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            top_reg     <= '0;
            count_reg   <= '0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            remain_reg    <= remain_next;
            m_valid_reg   <= m_valid_next;
            m_status_reg  <= m_status_next;
            m_last_reg    <= m_last_next;
            m_ram_reg     <= m_ram_next;
        end
    end

    sqs_ram #(
        .WIDTH (sqs_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_data.value),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // read register holds while the walk is paused, so the payload stays put
    assign m_valid       = m_valid_reg;
    assign m_data.data   = m_ram_reg ? ram_rdata : '0;
    assign m_data.status = m_status_reg;
    assign m_data.last   = m_last_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_walk_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PRINT) |-> (remain_reg != '0) && !s_ready)
        else $error("print walk with nothing left or taking requests");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.cmd == sqs_pkg::CMD_POP && !empty)
        |=> (count_reg == $past(count_reg) - 1'b1) && !m_valid_reg)
        else $error("pop did not remove exactly one entry silently");

    a_walk_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_re && remain_reg == CNT_W'(1)) |=> m_valid_reg && m_last_reg
        && (state_reg == ST_IDLE))
        else $error("print walk did not end with a last result");
`endif

endmodule

// ===== rtl/core/sqs_ram.sv =====
// ----------------------------------------------------------------------------
// sqs_ram
// Simple dual-port RAM, one write and one read port, registered read data
// that holds its value while no read is enabled.
// ----------------------------------------------------------------------------
module sqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
